// ===== rtl/pics_pkg.sv =====
// Package for the inline-cache slot table: sizes, codes, payload structs.
// No dependencies; used by every module of the block except pics_ram.
`default_nettype none
package pics_pkg;
   localparam int NumSlots  = 256;
   localparam int MaxPairs  = 4;
   localparam int IdWidth   = 32;
   localparam int SlotBits  = $clog2(NumSlots);
   localparam int PairBits  = $clog2(MaxPairs);
   localparam int CountBits = $clog2(MaxPairs + 1);

   localparam logic [1:0] MODE_EMPTY = 2'd0;
   localparam logic [1:0] MODE_MONO  = 2'd1;
   localparam logic [1:0] MODE_POLY  = 2'd2;
   localparam logic [1:0] MODE_MEGA  = 2'd3;

   localparam logic [2:0] OUT_MISS    = 3'd0;
   localparam logic [2:0] OUT_HIT     = 3'd1;
   localparam logic [2:0] OUT_MEGA    = 3'd2;
   localparam logic [2:0] OUT_ADDED   = 3'd3;
   localparam logic [2:0] OUT_IGNORED = 3'd4;
   localparam logic [2:0] OUT_TO_MEGA = 3'd5;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic        operation;
      logic        keyed;
      logic [7:0]  slot;
      logic [31:0] name_key;
      logic [31:0] class_id;
      logic [31:0] handler_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [31:0] handler_out;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // register request, issue memory reads
      logic execute;   // decide and write back
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/pics_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pics_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/pics_ctrl.sv =====
// Controller: accept, read, execute/respond sequence.
// Depends on pics_pkg.
`default_nettype none
module pics_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pics_pkg::cmd_type     cmd
);
   import pics_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/pics_dp.sv =====
// Datapath: slot metadata and name and pair stores in RAMs, compare and update.
// Depends on pics_pkg and pics_ram.
`default_nettype none
module pics_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  pics_pkg::cmd_type      cmd,
   input  pics_pkg::req_type      req_data,
   output pics_pkg::rsp_type      rsp_data
);
   import pics_pkg::*;

   localparam int MetaBits = 3 + CountBits;

   // a slot only returns to empty at reset, so one bit per slot marks it as written
   logic [NumSlots-1:0]  used_ff;
   logic [MetaBits-1:0]  meta_rd, meta_wr;
   logic                 cur_used;

   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [1:0]           mode_in;
   logic [CountBits-1:0] count_in;
   logic                 meta_we, skeyed_in;

   logic [SlotBits-1:0]  slot_idx;
   logic [SlotBits-1:0]  ram_slot;
   logic                 name_we;
   logic [IdWidth-1:0]   name_rd;
   logic [MaxPairs-1:0]  pair_we;
   logic [IdWidth-1:0]   cls_rd [MaxPairs];
   logic [31:0]          hnd_rd [MaxPairs];

   logic [1:0]           cur_mode;
   logic                 cur_keyed;
   logic [CountBits-1:0] cur_count;
   logic                 name_ok, key_ok;
   logic [IdWidth-1:0]   name_q, cls_q;

   assign slot_idx  = req_ff.slot[SlotBits-1:0];
   assign ram_slot  = cmd.capture ? req_data.slot[SlotBits-1:0] : slot_idx;
   assign cur_used  = used_ff[slot_idx];
   assign cur_mode  = cur_used ? meta_rd[MetaBits-1 -: 2] : MODE_EMPTY;
   assign cur_keyed = cur_used && meta_rd[CountBits];
   assign cur_count = cur_used ? meta_rd[CountBits-1:0] : '0;
   assign meta_wr   = {mode_in, skeyed_in, count_in};
   assign name_q    = req_ff.name_key[IdWidth-1:0];
   assign cls_q     = req_ff.class_id[IdWidth-1:0];
   assign key_ok    = (cur_keyed == req_ff.keyed);
   assign name_ok   = !req_ff.keyed || (name_rd == name_q);

   pics_ram #(.Width(MetaBits), .Depth(NumSlots)) u_meta (
      .clock(clock), .wr_en(meta_we), .addr(ram_slot),
      .wr_data(meta_wr), .rd_data(meta_rd));

   pics_ram #(.Width(IdWidth), .Depth(NumSlots)) u_name (
      .clock(clock), .wr_en(name_we), .addr(ram_slot),
      .wr_data(name_q), .rd_data(name_rd));

   // one bank per pair position so the whole slot reads at once
   for (genvar p = 0; p < MaxPairs; p++) begin : g_bank
      pics_ram #(.Width(IdWidth), .Depth(NumSlots)) u_cls (
         .clock(clock), .wr_en(pair_we[p]), .addr(ram_slot),
         .wr_data(cls_q), .rd_data(cls_rd[p]));
      pics_ram #(.Width(32), .Depth(NumSlots)) u_hnd (
         .clock(clock), .wr_en(pair_we[p]), .addr(ram_slot),
         .wr_data(req_ff.handler_in), .rd_data(hnd_rd[p]));
   end

   always_comb begin
      rsp_in    = rsp_ff;
      mode_in   = cur_mode;
      count_in  = cur_count;
      skeyed_in = cur_keyed;
      meta_we   = 1'b0;
      name_we   = 1'b0;
      pair_we   = '0;
      if (cmd.execute) begin
         rsp_in.handler_out = '0;
         if (req_ff.operation == OP_LOOKUP) begin
            priority if (cur_mode == MODE_EMPTY) rsp_in.outcome = OUT_MISS;
            else if (cur_mode == MODE_MEGA) rsp_in.outcome = OUT_MEGA;
            else if (!key_ok || !name_ok) rsp_in.outcome = OUT_MISS;
            else begin
               rsp_in.outcome = OUT_MISS;
               // first match in insertion order wins
               for (int i = MaxPairs - 1; i >= 0; i--) begin
                  if ((CountBits'(i) < cur_count) && (cls_rd[i] == cls_q)) begin
                     rsp_in.outcome     = OUT_HIT;
                     rsp_in.handler_out = hnd_rd[i];
                  end
               end
            end
         end else begin
            priority if (cur_mode == MODE_EMPTY) begin
               rsp_in.outcome = OUT_ADDED;
               meta_we   = 1'b1;
               mode_in   = MODE_MONO;
               skeyed_in = req_ff.keyed;
               count_in  = CountBits'(1);
               name_we   = req_ff.keyed;
               pair_we[0] = 1'b1;
            end else if (cur_mode == MODE_MEGA || !key_ok || !name_ok) begin
               rsp_in.outcome = OUT_IGNORED;
            end else if (cur_count >= CountBits'(MaxPairs)) begin
               if (req_ff.keyed) begin
                  rsp_in.outcome = OUT_TO_MEGA;
                  meta_we  = 1'b1;
                  mode_in  = MODE_MEGA;
                  count_in = '0;
               end else begin
                  rsp_in.outcome = OUT_IGNORED;
               end
            end else begin
               rsp_in.outcome = OUT_ADDED;
               meta_we  = 1'b1;
               mode_in  = MODE_POLY;
               count_in = cur_count + CountBits'(1);
               pair_we[cur_count[PairBits-1:0]] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      rsp_ff <= rsp_in;
      if (reset) begin
         used_ff <= '0;
      end else if (meta_we) begin
         used_ff[slot_idx] <= 1'b1;
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/polymorphic_inline_cache_slots.sv =====
// Top level of the inline-cache slot table: controller plus datapath.
// Depends on pics_pkg, pics_ctrl, pics_dp.
//
//   channel | direction | payload
//   req_    | in        | req_type (operation, keyed, slot, name_key, class_id, handler_in)
//   rsp_    | out       | rsp_type (outcome, handler_out)
//
// One transaction at a time: accept with the registered RAM read, a step to decide
// and write back, then the response is held until taken.
// Synchronous reset empties all slots at once; stalls on rsp_ hold the block.
`default_nettype none
module polymorphic_inline_cache_slots (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  pics_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pics_pkg::rsp_type       rsp_data
);
   import pics_pkg::*;

   cmd_type cmd;

   pics_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd));

   pics_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .rsp_data(rsp_data));
endmodule
`default_nettype wire

// ===== rtl/pics_checker.sv =====
// Port-level checks for the inline-cache slot table, bound to the top level.
// Depends on pics_pkg.
`default_nettype none
module pics_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input pics_pkg::rsp_type      rsp_data
);
   import pics_pkg::*;

   a_one_outstanding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid) else $error("response late");

   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.outcome <= OUT_TO_MEGA)) else $error("bad outcome");

   a_handler_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.outcome != OUT_HIT) |-> (rsp_data.handler_out == '0))
      else $error("handler on non-hit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped");
endmodule

bind polymorphic_inline_cache_slots pics_checker u_pics_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
`default_nettype wire
